### rtl/gdd_pkg.sv
package gdd_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam int unsigned WAIT_RESET = 900;

  // controller -> datapath commands
  typedef struct packed {
    logic load_item;    // capture the input transfer
    logic write_point;  // store the new point in the ring
    logic scan_clear;   // reset scan index and accumulators
    logic scan_step;    // advance the scan by one entry
    logic rd_issue;     // issue a RAM read at the scan index
    logic sum_acc;      // accumulate returned data
    logic div_start;    // start the mean divider
    logic div_step;     // one divider iteration
    logic dev_acc;      // evaluate one deviation
    logic trim_commit;  // apply trim found during sample scan
    logic empty_hist;   // empty the history
    logic set_latch;
    logic clr_latch;
    logic res_load;     // load result register
    logic res_stat;     // stationary value for the result
  } gdd_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       empty;
    logic       full;
    logic       too_early;
    logic       scan_last;
    logic       old_hit;
    logic       dev_fail;
    logic       div_done;
    logic       latch;
  } gdd_sts_t;

endpackage

### rtl/gaze_dwell_detector.sv
// Channel | Direction | Handshake       | Payload
// input   | in        | in_valid/stall  | kind, x_pos, y_pos, now_ms
// result  | out       | out_valid/stall | stationary, held_points
// config  | in        | APB write/read  | wait_time_ms @0, radius_limit @4
//
// One item at a time. A clear empties the history; a sample walks the ring
// from newest entry to the first expired one and drops the entries past it;
// a query checks that its oldest entry aged, sums N entries, divides one
// quotient bit per cycle (24 steps at depth 64), tests up to N deviations.
// Reset clears the ring pointers, count and latch; the ring RAMs need none.
// A stalled result holds; the next input transfer may be taken meanwhile,
// and its result waits until the held one is taken.
module gaze_dwell_detector #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic [31:0]       now_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              stationary_o,
  output logic [6:0]        held_points_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam logic [2:0] ADDR_WAIT   = 3'd0;
  localparam logic [2:0] ADDR_RADIUS = 3'd4;

  logic [15:0] wait_q;
  logic [11:0] radius_q;
  gdd_pkg::gdd_cmd_t cmd;
  gdd_pkg::gdd_sts_t sts;

  assign pready = 1'b1;

  // register file: write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q   <= 16'(gdd_pkg::WAIT_RESET);
      radius_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ADDR_WAIT:   wait_q   <= pwdata[15:0];
        ADDR_RADIUS: radius_q <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_WAIT:   prdata = {16'd0, wait_q};
      ADDR_RADIUS: prdata = {20'd0, radius_q};
      default:     prdata = '0;
    endcase
  end

  gdd_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd));

  gdd_datapath #(.HistoryDepth(HISTORY_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .kind_i, .x_pos_i, .y_pos_i,
    .now_ms_i, .wait_time_ms_i(wait_q), .radius_limit_i(radius_q),
    .stationary_o, .held_points_o);
endmodule

### rtl/gdd_ram.sv
module gdd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/gdd_ctrl.sv
module gdd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  gdd_pkg::gdd_sts_t sts_i,
  output gdd_pkg::gdd_cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_TRIM   = 4'd2;
  localparam logic [3:0] S_TRIMW  = 4'd3;
  localparam logic [3:0] S_SUM    = 4'd4;
  localparam logic [3:0] S_SUMW   = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_DEV    = 4'd7;
  localparam logic [3:0] S_DEVW   = 4'd8;
  localparam logic [3:0] S_DEVC   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_TIMEW  = 4'd11;
  localparam logic [3:0] S_TIMEC  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       outv_q, outv_d;

  assign out_valid_o = outv_q;
  assign in_stall_o  = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    outv_d  = outv_q && out_stall_i;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.kind)
          gdd_pkg::KIND_SAMPLE: begin
            cmd_o.write_point = 1'b1;
            cmd_o.scan_clear  = 1'b1;
            state_d = S_TRIM;
          end
          gdd_pkg::KIND_QUERY: begin
            if (sts_i.empty) begin
              state_d = S_OUT;
            end else begin
              cmd_o.scan_clear = 1'b1;
              cmd_o.rd_issue   = 1'b1;
              state_d = S_TIMEW;
            end
          end
          gdd_pkg::KIND_CLEAR: begin
            cmd_o.empty_hist = 1'b1;
            state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_TIMEW: state_d = S_TIMEC;
      S_TIMEC: begin
        if (sts_i.too_early) begin
          state_d = S_OUT;
        end else begin
          cmd_o.scan_clear = 1'b1;
          state_d = S_SUM;
        end
      end
      // newest-to-oldest search for the first expired entry
      S_TRIM: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_TRIMW;
      end
      S_TRIMW: state_d = S_DEVC;
      S_SUM: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_SUMW;
      end
      S_SUMW: begin
        cmd_o.sum_acc = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = S_SUM;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.scan_clear = 1'b1;
          state_d = S_DEV;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DEV: begin
        cmd_o.rd_issue = 1'b1;
        state_d = S_DEVW;
      end
      S_DEVW: begin
        cmd_o.dev_acc = 1'b1;
        state_d = S_DEVC;
      end
      S_DEVC: begin
        if (sts_i.kind == gdd_pkg::KIND_SAMPLE) begin
          if (sts_i.old_hit) begin
            cmd_o.trim_commit = 1'b1;
            state_d = S_OUT;
          end else if (sts_i.scan_last) begin
            state_d = S_OUT;
          end else begin
            cmd_o.scan_step = 1'b1;
            state_d = S_TRIM;
          end
        end else if (sts_i.dev_fail) begin
          cmd_o.clr_latch = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.scan_last) begin
          if (!sts_i.latch) begin
            cmd_o.empty_hist = 1'b1;
            cmd_o.set_latch  = 1'b1;
            cmd_o.res_stat   = 1'b1;
          end
          state_d = S_OUT;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = S_DEV;
        end
      end
      S_OUT: begin
        if (!(outv_q && out_stall_i)) begin
          cmd_o.res_load = 1'b1;
          outv_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // res_stat must survive to S_OUT: datapath latches it when asserted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
    end
  end
endmodule

### rtl/gdd_datapath.sv
module gdd_datapath #(
  parameter int unsigned HistoryDepth = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdd_pkg::gdd_cmd_t cmd_i,
  output gdd_pkg::gdd_sts_t sts_o,
  input  logic [1:0]        kind_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic [31:0]       now_ms_i,
  input  logic [15:0]       wait_time_ms_i,
  input  logic [11:0]       radius_limit_i,
  output logic              stationary_o,
  output logic [6:0]        held_points_o
);
  localparam int unsigned AW = $clog2(HistoryDepth);
  localparam int unsigned CW = $clog2(HistoryDepth + 1);
  localparam int unsigned SW = 16 + CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(HistoryDepth);

  // fold a sum of two ring positions back into the ring
  function automatic logic [AW-1:0] wrap_slot(logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= (AW+1)'(HistoryDepth)) ? s - (AW+1)'(HistoryDepth) : s;
    return t[AW-1:0];
  endfunction

  logic [1:0]         kind_q;
  logic signed [15:0] x_q, y_q;
  logic [31:0]        now_q;
  logic [AW-1:0]      oldest_q;
  logic [CW-1:0]      count_q;
  logic               latch_q;
  logic [CW-1:0]      idx_q;
  logic signed [SW-1:0] sx_q, sy_q;
  logic               stat_q;
  logic               res_stat_q;
  logic [6:0]         res_cnt_q;
  logic [16:0]        adx_q, ady_q;

  // divider: magnitude restoring division, one quotient bit per step
  logic [SW-1:0]      qx_q, qy_q, rx_q, ry_q;
  logic [$clog2(SW+1)-1:0] dcnt_q;
  logic               nx_q, ny_q;

  logic [AW-1:0] wslot, rslot, base_slot;
  logic [CW-1:0] eff_count;
  logic [15:0]   rd_x, rd_y;
  logic [31:0]   rd_t;
  logic [AW:0]   sum_slot;

  // after a sample write the effective count includes the new point
  assign base_slot = oldest_q;
  always_comb begin
    sum_slot = {1'b0, oldest_q} + {1'b0, idx_q[AW-1:0]};
    if (kind_q == gdd_pkg::KIND_SAMPLE) begin
      sum_slot = {1'b0, oldest_q} + {1'b0, AW'(count_q - 1'b1 - idx_q)};
    end
    rslot = wrap_slot(sum_slot);
  end
  logic [AW:0] wsum;
  logic [AW-1:0] ofs;
  assign ofs  = (count_q == DEPTH_C) ? AW'(HistoryDepth - 1) : count_q[AW-1:0];
  logic [AW-1:0] old_nx;
  assign old_nx = (count_q == DEPTH_C) ? wrap_slot({1'b0, oldest_q} + 1'b1) : oldest_q;
  assign wsum  = {1'b0, old_nx} + {1'b0, ofs};
  assign wslot = wrap_slot(wsum);
  assign eff_count = count_q;

  gdd_ram #(.Width(16), .Depth(HistoryDepth)) u_ram_x (
    .clk_i, .we_i(cmd_i.write_point), .waddr_i(wslot), .wdata_i(x_q),
    .raddr_i(rslot), .rdata_o(rd_x));
  gdd_ram #(.Width(16), .Depth(HistoryDepth)) u_ram_y (
    .clk_i, .we_i(cmd_i.write_point), .waddr_i(wslot), .wdata_i(y_q),
    .raddr_i(rslot), .rdata_o(rd_y));
  gdd_ram #(.Width(32), .Depth(HistoryDepth)) u_ram_t (
    .clk_i, .we_i(cmd_i.write_point), .waddr_i(wslot), .wdata_i(now_q),
    .raddr_i(rslot), .rdata_o(rd_t));

  logic [31:0] age;
  assign age = now_q - rd_t;
  logic aged;
  assign aged = age > {16'd0, wait_time_ms_i};

  // deviation test, registered multiply inputs then compare
  logic signed [SW-1:0] mx, my;
  assign mx = nx_q ? -$signed(qx_q) : $signed(qx_q);
  assign my = ny_q ? -$signed(qy_q) : $signed(qy_q);
  logic signed [SW:0] dx, dy;
  assign dx = (SW+1)'($signed(rd_x)) - (SW+1)'(mx);
  assign dy = (SW+1)'($signed(rd_y)) - (SW+1)'(my);
  logic [16:0] adx, ady;
  assign adx = dx[SW] ? 17'(-dx) : 17'(dx);
  assign ady = dy[SW] ? 17'(-dy) : 17'(dy);
  logic [33:0] dxx, dyy;
  assign dxx = adx_q * adx_q;
  assign dyy = ady_q * ady_q;
  logic [34:0] d2;
  assign d2 = {1'b0, dxx} + {1'b0, dyy};
  logic [23:0] r2;
  assign r2 = radius_limit_i * radius_limit_i;

  logic [SW-1:0] ax, ay, trx, try_;
  assign ax = sx_q[SW-1] ? SW'(-sx_q) : SW'(sx_q);
  assign ay = sy_q[SW-1] ? SW'(-sy_q) : SW'(sy_q);
  assign trx = {rx_q[SW-2:0], qx_q[SW-1]};
  assign try_ = {ry_q[SW-2:0], qy_q[SW-1]};
  logic [SW-1:0] dvs;
  assign dvs = SW'(count_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_i; x_q <= x_pos_i; y_q <= y_pos_i; now_q <= now_ms_i;
    end
    if (cmd_i.scan_clear) begin
      idx_q <= '0; sx_q <= '0; sy_q <= '0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.sum_acc) begin
      sx_q <= sx_q + SW'($signed(rd_x));
      sy_q <= sy_q + SW'($signed(rd_y));
    end
    if (cmd_i.dev_acc) begin
      adx_q <= adx; ady_q <= ady;
    end
  end

  // divider input loaded the cycle after the sum settles
  logic div_load_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_load_q <= 1'b0;
    else div_load_q <= cmd_i.div_start;
  end
  always_ff @(posedge clk_i) begin
    if (div_load_q) begin
      qx_q <= ax; qy_q <= ay;
      nx_q <= sx_q[SW-1]; ny_q <= sy_q[SW-1];
      rx_q <= '0; ry_q <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (trx >= dvs) begin
        rx_q <= trx - dvs; qx_q <= {qx_q[SW-2:0], 1'b1};
      end else begin
        rx_q <= trx; qx_q <= {qx_q[SW-2:0], 1'b0};
      end
      if (try_ >= dvs) begin
        ry_q <= try_ - dvs; qy_q <= {qy_q[SW-2:0], 1'b1};
      end else begin
        ry_q <= try_; qy_q <= {qy_q[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0; count_q <= '0; latch_q <= 1'b0;
      stat_q <= 1'b0; res_stat_q <= 1'b0; res_cnt_q <= '0;
    end else begin
      if (cmd_i.write_point) begin
        oldest_q <= old_nx;
        count_q  <= (count_q == DEPTH_C) ? DEPTH_C : count_q + 1'b1;
      end
      if (cmd_i.trim_commit) begin
        oldest_q <= rslot;
        count_q  <= idx_q + 1'b1;
      end
      if (cmd_i.empty_hist) begin
        oldest_q <= '0; count_q <= '0;
      end
      if (cmd_i.set_latch) latch_q <= 1'b1;
      if (cmd_i.clr_latch) latch_q <= 1'b0;
      if (cmd_i.load_item) stat_q <= 1'b0;
      if (cmd_i.res_stat) stat_q <= 1'b1;
      if (cmd_i.res_load) begin
        res_stat_q <= stat_q;
        res_cnt_q  <= 7'(eff_count);
      end
    end
  end

  assign stationary_o  = res_stat_q;
  assign held_points_o = res_cnt_q;

  assign sts_o.kind      = kind_q;
  assign sts_o.empty     = count_q == '0;
  assign sts_o.full      = count_q == DEPTH_C;
  assign sts_o.too_early = !aged;
  assign sts_o.scan_last = idx_q == count_q - 1'b1;
  assign sts_o.old_hit   = aged;
  assign sts_o.dev_fail  = d2 > {11'd0, r2};
  assign sts_o.div_done  = !div_load_q && dcnt_q == ($clog2(SW+1))'(SW);
  assign sts_o.latch     = latch_q;

  logic unused;
  assign unused = ^{base_slot};
endmodule

### rtl/gdd_checker.sv
module gdd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       stationary_o,
  input logic [6:0] held_points_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(held_points_o))
    else $error("stalled result changed");
  a_stat_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stationary_o |-> held_points_o == 7'd0)
    else $error("dwell reported with points held");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted while busy");
endmodule

bind gaze_dwell_detector gdd_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .stationary_o, .held_points_o);
